// ----- rtl/assert_macros.svh -----
// Assertion helpers used by pe_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pe_pkg.sv -----
package pe_pkg;

    // width of the value and result fields
    localparam int FIELD_W = 32;

    // widest multiplier operand of the shared MAC
    localparam int MUL_W = 32;

    localparam int MAX_COEFFS_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;

    // beat kinds on the input channel
    localparam logic FUNC_COEFF = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

endpackage

// ----- rtl/polynomial_evaluator.sv -----
// Channel  Dir  Handshake          Payload
// s_       in   s_valid / s_ready  s_func, s_value, s_last
// m_       out  m_valid / m_ready  m_result, m_line_end, m_overflowed
//
// A coefficient beat leaves s_ready high.
// A point beat holds s_ready low through N Horner steps of P partial products
// each on the shared MAC, N being the stored coefficient count (P is 1 for
// VALUE_BITS up to 32, 3 up to 64) and until the result is loaded into m_;
// an empty polynomial skips the MAC. Reset (aresetn low, synchronous) empties
// the polynomial; the store itself is not cleared, only entries below the count are ever read.
// A result held on a stalled m_ channel does not stop coefficient loading.
module polynomial_evaluator #(
    parameter int MAX_COEFFS = pe_pkg::MAX_COEFFS_DEF,
    parameter int VALUE_BITS = pe_pkg::VALUE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic signed [pe_pkg::FIELD_W-1:0]  s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pe_pkg::FIELD_W-1:0]  m_result,
    output logic                               m_line_end,
    output logic                               m_overflowed
);

    // MAC chunking: VALUE_BITS is cut into chunks no wider than the multiplier
    localparam int CW    = (VALUE_BITS < pe_pkg::MUL_W) ? VALUE_BITS : pe_pkg::MUL_W;
    localparam int NCH   = (VALUE_BITS + CW - 1) / CW;
    localparam int PW    = 2 * CW;
    localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int CNT_W = $clog2(MAX_COEFFS + 1);
    localparam int FW    = pe_pkg::FIELD_W;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DRAIN} state_t;

    // control
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   after_pt_reg, after_pt_next;
    logic                   dropped_reg, dropped_next;
    logic                   m_valid_reg, m_valid_next;

    // datapath
    logic [AW-1:0]          k_reg, k_next;
    logic [CIW-1:0]         pi_reg, pi_next;
    logic [CIW-1:0]         pj_reg, pj_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [VALUE_BITS-1:0]  sum_reg, sum_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   pend_ovf_reg, pend_ovf_next;
    logic [FW-1:0]          res_reg, res_next;
    logic                   line_end_reg, line_end_next;
    logic                   ovf_reg, ovf_next;

    // coefficient store
    logic [FW-1:0]          mem [MAX_COEFFS];
    logic [FW-1:0]          rd_data_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;

    // MAC signals
    logic [NCH*CW-1:0]      acc_ext;
    logic [NCH*CW-1:0]      val_ext;
    logic [CW-1:0]          a_chunk;
    logic [CW-1:0]          b_chunk;
    logic [PW-1:0]          prod;
    logic [CIW:0]           sh_idx;
    logic [VALUE_BITS-1:0]  pp;
    logic [VALUE_BITS-1:0]  coef_ext;
    logic                   first_pair;
    logic                   row_end;
    logic                   step_done;
    logic                   k_last;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_result     = signed'(res_reg);
    assign m_line_end   = line_end_reg;
    assign m_overflowed = ovf_reg;

    // one partial product of acc * point per cycle, chunk pi of acc by chunk pj of point
    assign acc_ext    = (NCH*CW)'(acc_reg);
    assign val_ext    = (NCH*CW)'(val_reg);
    assign a_chunk    = acc_ext[pi_reg*CW +: CW];
    assign b_chunk    = val_ext[pj_reg*CW +: CW];
    assign prod       = PW'(a_chunk) * PW'(b_chunk);
    assign sh_idx     = {1'b0, pi_reg} + {1'b0, pj_reg};
    assign pp         = VALUE_BITS'(prod << (sh_idx * CW));
    assign coef_ext   = VALUE_BITS'(signed'(rd_data_reg));
    assign first_pair = (pi_reg == '0) && (pj_reg == '0);
    // only products below 2^VALUE_BITS matter: chunk pairs with pi + pj < NCH
    assign row_end    = (sh_idx == (CIW+1)'(NCH - 1));
    assign step_done  = row_end && (pi_reg == CIW'(NCH - 1));
    assign sum_next   = (first_pair ? coef_ext : sum_reg) + pp;
    assign k_last     = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        after_pt_next  = after_pt_reg;
        dropped_next   = dropped_reg;
        m_valid_next   = m_valid_reg;
        k_next         = k_reg;
        pi_next        = pi_reg;
        pj_next        = pj_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        pend_last_next = pend_last_reg;
        pend_ovf_next  = pend_ovf_reg;
        res_next       = res_reg;
        line_end_next  = line_end_reg;
        ovf_next       = ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                k_next  = '0;
                pi_next = '0;
                pj_next = '0;
                if (s_valid) begin
                    if (s_func == pe_pkg::FUNC_COEFF) begin
                        if (after_pt_reg) begin
                            // first coefficient of a new polynomial
                            wr_en         = 1'b1;
                            wr_addr       = '0;
                            cnt_next      = CNT_W'(1);
                            dropped_next  = 1'b0;
                            after_pt_next = 1'b0;
                        end else if (cnt_reg < CNT_W'(MAX_COEFFS)) begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            dropped_next = 1'b1;
                        end
                    end else begin
                        after_pt_next  = 1'b1;
                        pend_last_next = s_last;
                        pend_ovf_next  = dropped_reg;
                        val_next       = VALUE_BITS'(s_value);
                        acc_next       = '0;
                        state_next     = (cnt_reg == '0) ? ST_DRAIN : ST_EVAL;
                    end
                end
            end

            ST_EVAL: begin
                if (step_done) begin
                    pi_next  = '0;
                    pj_next  = '0;
                    acc_next = sum_next;
                    if (k_last) begin
                        state_next = ST_DRAIN;
                    end else begin
                        k_next = k_reg + AW'(1);
                    end
                end else if (row_end) begin
                    pi_next = pi_reg + CIW'(1);
                    pj_next = '0;
                end else begin
                    pj_next = pj_reg + CIW'(1);
                end
            end

            ST_DRAIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    res_next      = FW'(signed'(acc_reg));
                    line_end_next = pend_last_reg;
                    ovf_next      = pend_ovf_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            after_pt_reg <= 1'b1;
            dropped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            after_pt_reg <= after_pt_next;
            dropped_reg  <= dropped_next;
            m_valid_reg  <= m_valid_next;
        end
        k_reg         <= k_next;
        pi_reg        <= pi_next;
        pj_reg        <= pj_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        val_reg       <= val_next;
        pend_last_reg <= pend_last_next;
        pend_ovf_reg  <= pend_ovf_next;
        res_reg       <= res_next;
        line_end_reg  <= line_end_next;
        ovf_reg       <= ovf_next;
    end

    // store: read address runs one step ahead so data is ready on entering each step
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        rd_data_reg <= mem[k_next];
    end

endmodule

// ----- rtl/pe_checker.sv -----
`include "assert_macros.svh"

module pe_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_func,
    input logic signed [pe_pkg::FIELD_W-1:0]  s_value,
    input logic                               s_last,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [pe_pkg::FIELD_W-1:0]  m_result,
    input logic                               m_line_end,
    input logic                               m_overflowed
);

    logic pt_beat;
    logic coef_beat;
    logic out_stall;

    assign pt_beat   = s_valid && s_ready && (s_func == pe_pkg::FUNC_POINT);
    assign coef_beat = s_valid && s_ready && (s_func == pe_pkg::FUNC_COEFF);
    assign out_stall = m_valid && !m_ready;

    // a point drops s_ready in the next cycle
    `ASSERT_NEXT(a_point_busy, aclk, aresetn, pt_beat, !s_ready)

    // a coefficient leaves s_ready high in the next cycle
    `ASSERT_NEXT(a_coef_one_cycle, aclk, aresetn, coef_beat, s_ready)

    // a result only appears at the end of an evaluation
    `ASSERT_IMPL(a_result_after_eval, aclk, aresetn, $rose(m_valid), $past(!s_ready))

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall,
                 m_valid && $stable(m_result) && $stable(m_line_end) && $stable(m_overflowed))

endmodule

bind polynomial_evaluator pe_checker u_pe_checker (.*);

// ----- dv/pe_result_checker.sv -----
// Watches both channels of polynomial_evaluator, keeps its own copy of the
// polynomial and checks every result beat against the oldest prediction.
module pe_result_checker
    import pe_pkg::*;
#(
    parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_func,
    input  logic signed [FIELD_W-1:0]  s_value,
    input  logic                       s_last,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [FIELD_W-1:0]  m_result,
    input  logic                       m_line_end,
    input  logic                       m_overflowed,
    output int                         mismatches,
    output int                         outstanding
);

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               line_end;
        logic               overflowed;
    } point_value_t;

    point_value_t        pending_values[$];
    logic [FIELD_W-1:0]  coeffs[MAX_COEFFS];
    int                  n_coeffs = 0;
    logic                new_poly = 1'b1;
    logic                dropped = 1'b0;
    int                  errors = 0;
    int                  pending_count = 0;

    assign mismatches  = errors;
    assign outstanding = pending_count;

    // Horner over the stored coefficients; truncation to the field width is
    // exactly the two's complement wrap of the block.
    function automatic logic [FIELD_W-1:0] eval_at(input logic [FIELD_W-1:0] x);
        logic [FIELD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < n_coeffs; k++)
            acc = acc * x + coeffs[k];
        return acc;
    endfunction

    task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        point_value_t want;
        if (!aresetn) begin
            pending_values.delete();
            n_coeffs = 0;
            new_poly = 1'b1;
            dropped  = 1'b0;
        end else begin
            // result side first: a beat leaving now is never the one arriving now
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_result);
                end else begin
                    want = pending_values.pop_front();
                    compare_field("result", want.value, m_result);
                    compare_field("line_end", FIELD_W'(want.line_end), FIELD_W'(m_line_end));
                    compare_field("overflowed", FIELD_W'(want.overflowed),
                                  FIELD_W'(m_overflowed));
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_COEFF) begin
                    if (new_poly) begin
                        n_coeffs = 0;
                        dropped  = 1'b0;
                        new_poly = 1'b0;
                    end
                    if (n_coeffs < MAX_COEFFS) begin
                        coeffs[n_coeffs] = s_value;
                        n_coeffs++;
                    end else begin
                        dropped = 1'b1;
                    end
                end else begin
                    pending_values.push_back('{value: eval_at(s_value),
                                               line_end: s_last,
                                               overflowed: dropped});
                    new_poly = 1'b1;
                end
            end
        end
        pending_count = pending_values.size();
    end

endmodule

// ----- dv/polynomial_evaluator_test.sv -----
// Stimulus and verdict for polynomial_evaluator; all prediction and
// comparison lives in pe_result_checker.
module polynomial_evaluator_test;
    import pe_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;       // long m_ready hold-off
    localparam int PHASE_BEATS = 600;       // input beats per idling phase
    localparam int DRAIN_CYCLES = 64;       // margin after the last result has left

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_func = FUNC_COEFF;
    logic signed [FIELD_W-1:0] s_value = '0;
    logic                      s_last = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [FIELD_W-1:0] m_result;
    logic                      m_line_end;
    logic                      m_overflowed;

    int mismatches;
    int outstanding;

    // idling odds, in percent per cycle, changed phase by phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int beats_sent = 0;
    int cycle_count = 0;

    // hold-off handshake between stimulus and the receiver process:
    // stimulus bumps hold_requests, receiver serves it and counts its own cycles
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    polynomial_evaluator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_value      (s_value),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result     (m_result),
        .m_line_end   (m_line_end),
        .m_overflowed (m_overflowed)
    );

    pe_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_value      (s_value),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result     (m_result),
        .m_line_end   (m_line_end),
        .m_overflowed (m_overflowed),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off on request. While held,
    // the block keeps taking coefficients but stalls on a point once a result waits on m_.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Mix of corner values and full-range noise; small magnitudes keep some
    // results readable, full 32-bit draws exercise every bit of s_value.
    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5, 6: return FIELD_W'($signed($urandom_range(64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    // One beat on s_; may idle first. valid only drops when a gap is taken, so
    // back-to-back beats keep it high with a single assignment per edge.
    task automatic send_beat(input logic func, input logic [FIELD_W-1:0] val,
                             input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_value <= val;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // A well-formed line: coefficients (last is don't-care there, so random),
    // then points with last mostly on the final one.
    task automatic send_polynomial(input int n_coeffs, input int n_points);
        for (int i = 0; i < n_coeffs; i++)
            send_beat(FUNC_COEFF, pick_value(), 1'($urandom));
        for (int j = 0; j < n_points; j++)
            send_beat(FUNC_POINT, pick_value(),
                      (j == n_points - 1) ? ($urandom_range(9) != 0)
                                          : ($urandom_range(3) == 0));
    endtask

    // Mostly well-formed lines of varied degree; now and then stray beats.
    // Most polynomials are short so point latency stays low; a few fill or
    // overrun the store.
    task automatic run_random(input int target);
        int pick;
        int degree;
        while (beats_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                repeat ($urandom_range(3, 1))
                    send_beat(1'($urandom), $urandom, 1'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 60)
                    degree = $urandom_range(6, 1);
                else if (pick < 85)
                    degree = $urandom_range(20, 7);
                else if (pick < 95)
                    degree = $urandom_range(MAX_COEFFS_DEF, 21);
                else
                    degree = $urandom_range(MAX_COEFFS_DEF + 8, MAX_COEFFS_DEF + 1);
                send_polynomial(degree, $urandom_range(4, 1));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: light sender gaps, heavy receiver back-pressure
        send_idle_pct = 15;
        recv_idle_pct = 88;

        // points before any coefficient: empty polynomial, twice in a row
        send_beat(FUNC_POINT, 32'd7, 1'b0);
        send_beat(FUNC_POINT, 32'hFFFF_FFFD, 1'b1);

        // extremes: x*max + min, wraps at either end
        send_beat(FUNC_COEFF, 32'h7FFF_FFFF, 1'b0);
        send_beat(FUNC_COEFF, 32'h8000_0000, 1'b1);
        send_beat(FUNC_POINT, 32'h0000_0000, 1'b0);
        send_beat(FUNC_POINT, 32'h0000_0001, 1'b0);
        send_beat(FUNC_POINT, 32'hFFFF_FFFF, 1'b0);
        send_beat(FUNC_POINT, 32'h7FFF_FFFF, 1'b0);
        send_beat(FUNC_POINT, 32'h8000_0000, 1'b1);

        // coefficient after a point starts a fresh polynomial
        send_beat(FUNC_COEFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(FUNC_COEFF, 32'h0000_0000, 1'b0);
        send_beat(FUNC_COEFF, 32'h0000_0001, 1'b0);
        send_beat(FUNC_POINT, 32'h0000_0002, 1'b0);
        send_beat(FUNC_POINT, 32'hFFFF_FFFF, 1'b1);

        // alternating bit patterns on value
        send_beat(FUNC_COEFF, 32'hAAAA_AAAA, 1'b1);
        send_beat(FUNC_POINT, 32'h5555_5555, 1'b0);

        // store overrun leads the random part: two coefficients are dropped,
        // so overflowed must be set on both points
        send_polynomial(MAX_COEFFS_DEF + 2, 2);
        // the next polynomial must clear the flag again
        send_polynomial(3, 1);

        run_random(PHASE_BEATS);

        // phase two: the other way round
        send_idle_pct = 88;
        recv_idle_pct = 15;
        run_random(2 * PHASE_BEATS);

        // phase three: no idling; open with a long receiver hold-off while the
        // sender keeps offering beats, so the block fills and stalls s_ready
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random(3 * PHASE_BEATS);

        // drop valid at the edge of the last acceptance so no beat repeats
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
